[src/sorted_priority_queue_top_assert.svh]
// Assertion macros for the sorted priority queue, empty under synthesis.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset.
`define SPQ_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sorted priority queue check failed");
// Check that a trigger leads to a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("sorted priority queue sequence check failed");
`else
`define SPQ_ASSERT(label, cond)
`define SPQ_ASSERT_NEXT(label, trig, cons)
`endif

`endif

[src/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
package spq_pkg;

	localparam int SPQ_DEPTH = 16;
	localparam int VALUE_W   = 32;
	localparam int PRIO_W    = 15;
	localparam int OPRIO_W   = 16;
	localparam int OCC_W     = 5;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} spq_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	// Request beat
	typedef struct packed {
		spq_cmd_t                   command;
		logic signed [VALUE_W-1:0]  item_value;
		logic        [PRIO_W-1:0]   item_priority;
	} spq_req_t;

	// Response beat
	typedef struct packed {
		logic signed [VALUE_W-1:0]  out_value;
		logic signed [OPRIO_W-1:0]  out_priority;
		spq_status_t                status;
		logic        [OCC_W-1:0]    occupancy;
	} spq_rsp_t;

	// One stored entry
	typedef struct packed {
		logic signed [VALUE_W-1:0]  value;
		logic        [PRIO_W-1:0]   prio;
	} spq_entry_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctl_t;

endpackage

[src/spq_stream_if.sv]
// Valid/ready stream interface carrying one payload beat.
interface spq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[src/spq_cell.sv]
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  spq_ctl_t   ctl,
	input  logic       occ,
	input  spq_entry_t ins,
	input  spq_entry_t prev,
	input  logic       prev_lt,
	input  spq_entry_t next,
	output logic       lt,
	output spq_entry_t held
);

	spq_entry_t held_q;

	// Flag the slot as giving way to the new entry: empty or strictly lower priority
	assign lt   = !occ || (held_q.prio < ins.prio);
	assign held = held_q;

	// Advance on dequeue; on enqueue take the new entry at the boundary, else shift back
	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			held_q <= next;
		end else if (ctl.enq && lt) begin
			held_q <= prev_lt ? prev : ins;
		end
	end

endmodule

[src/sorted_priority_queue_top.sv]
// Sorted priority queue: a chain of DEPTH slots kept in descending priority order,
// highest at the head. Each request beat is an enqueue or a dequeue and yields exactly
// one response beat. An enqueue goes behind all entries of equal or higher priority;
// an enqueue to a full queue reports status full and changes nothing; a dequeue returns
// the head and moves every entry one slot forward; a dequeue of an empty queue returns
// value -1, priority -1 and status empty. The queue takes one beat per clock while the
// response side keeps up: every slot compares its own priority with the incoming one and
// picks its neighbor or the new entry in the same cycle. A new beat may enter in the
// cycle the previous response leaves; while a response waits unaccepted, the request
// side stalls. The response is registered and appears in the cycle after the request is
// accepted. No clearing is needed after reset; the queue is ready at once.
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	spq_stream_if.sink    req,
	spq_stream_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic             rsp_valid_q;
	spq_rsp_t         rsp_q;
	spq_rsp_t         rsp_d;
	spq_ctl_t         ctl;
	logic             accept;
	logic             is_deq;
	logic             full;
	logic             empty;
	spq_entry_t       ins;
	spq_entry_t       held [DEPTH];
	logic [DEPTH-1:0] lt;

	// Accept whenever the response register is free or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_deq    = (req.data.command == CMD_DEQ);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign ins.value = req.data.item_value;
	assign ins.prio  = req.data.item_priority;

	// Drive the chain command
	assign ctl.enq = accept && !is_deq && !full;
	assign ctl.deq = accept && is_deq && !empty;

	// Chain of slots
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_entry_t prev_e;
		spq_entry_t next_e;
		logic       prev_l;

		if (i == 0) begin : g_head
			assign prev_e = ins;
			assign prev_l = 1'b0;
		end else begin : g_body
			assign prev_e = held[i-1];
			assign prev_l = lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_e = held[i];
		end else begin : g_link
			assign next_e = held[i+1];
		end

		spq_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.occ     (CW'(i) < count_q),
			.ins     (ins),
			.prev    (prev_e),
			.prev_lt (prev_l),
			.next    (next_e),
			.lt      (lt[i]),
			.held    (held[i])
		);
	end

	// Update the fill count
	always_comb begin
		count_d = count_q;
		if (ctl.enq) begin
			count_d = count_q + CW'(1);
		end else if (ctl.deq) begin
			count_d = count_q - CW'(1);
		end
	end

	// Build the response beat
	always_comb begin
		rsp_d.out_value    = '0;
		rsp_d.out_priority = '0;
		rsp_d.status       = ST_DONE;
		rsp_d.occupancy    = OCC_W'(count_d);
		if (is_deq) begin
			if (empty) begin
				rsp_d.out_value    = '1;
				rsp_d.out_priority = '1;
				rsp_d.status       = ST_EMPTY;
			end else begin
				rsp_d.out_value    = held[0].value;
				rsp_d.out_priority = {1'b0, held[0].prio};
			end
		end else if (full) begin
			rsp_d.status = ST_FULL;
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Checks
	`SPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`SPQ_ASSERT(a_head_sorted, (count_q < CW'(2)) || (held[0].prio >= held[1].prio))
	`SPQ_ASSERT_NEXT(a_deq_count, ctl.deq, count_q == $past(count_q) - CW'(1))
	`SPQ_ASSERT_NEXT(a_enq_count, ctl.enq, count_q == $past(count_q) + CW'(1))

endmodule

[sim/sorted_priority_queue_top_tb.sv]
// Self-checking testbench for the sorted priority queue: random enqueue/dequeue traffic.
module sorted_priority_queue_top_tb;
	import spq_pkg::*;

	localparam int ITEM_GOAL   = 1750;
	localparam int STALL_PCT   = 37;
	localparam int HANG_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 8;

	// Shadow of the queue contents; predicts every response and checks it in order.
	class priority_shadow;
		logic signed [VALUE_W-1:0] slot_value[SPQ_DEPTH];
		logic        [PRIO_W-1:0]  slot_prio[SPQ_DEPTH];
		int       held;
		spq_rsp_t awaited[$];
		int       errors;
		int       n_enq, n_full, n_deq, n_empty, peak, n_checked;

		function new();
			held = 0;
			errors = 0;
			n_enq = 0; n_full = 0; n_deq = 0; n_empty = 0; peak = 0; n_checked = 0;
		endfunction

		// Apply one accepted request beat and queue the response it must produce.
		function void note_request(spq_req_t r);
			spq_rsp_t e;
			int pos;
			e = '0;
			e.status = ST_DONE;
			if (r.command == CMD_ENQ) begin
				if (held >= SPQ_DEPTH) begin
					e.status = ST_FULL;
					n_full++;
				end else begin
					// Move lower-priority entries back until the slot is found.
					pos = held;
					while (pos > 0 && slot_prio[pos-1] < r.item_priority) begin
						slot_value[pos] = slot_value[pos-1];
						slot_prio[pos]  = slot_prio[pos-1];
						pos--;
					end
					slot_value[pos] = r.item_value;
					slot_prio[pos]  = r.item_priority;
					held++;
					n_enq++;
					if (held > peak) peak = held;
				end
			end else begin
				if (held == 0) begin
					e.out_value    = -1;
					e.out_priority = -1;
					e.status       = ST_EMPTY;
					n_empty++;
				end else begin
					e.out_value    = slot_value[0];
					e.out_priority = {1'b0, slot_prio[0]};
					for (int i = 0; i + 1 < held; i++) begin
						slot_value[i] = slot_value[i+1];
						slot_prio[i]  = slot_prio[i+1];
					end
					held--;
					n_deq++;
				end
			end
			e.occupancy = held[OCC_W-1:0];
			awaited.push_back(e);
		endfunction

		function void field_check(string name, longint unsigned exp, longint unsigned got);
			if (exp != got) begin
				$display("%0t: mismatch on %s: expected 'h%0h, actual 'h%0h",
					$time, name, exp, got);
				errors++;
			end
		endfunction

		// Compare a response beat with the oldest prediction.
		function void check_response(spq_rsp_t got);
			spq_rsp_t e;
			if (awaited.size() == 0) begin
				$display("%0t: response with nothing awaited: expected none, actual %p",
					$time, got);
				errors++;
				return;
			end
			e = awaited.pop_front();
			n_checked++;
			field_check("out_value", e.out_value, got.out_value);
			field_check("out_priority", e.out_priority, got.out_priority);
			field_check("status", e.status, got.status);
			field_check("occupancy", e.occupancy, got.occupancy);
		endfunction
	endclass

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} traffic_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   quiet_cycles = 0;
	int   sent = 0;
	priority_shadow sb;

	spq_stream_if #(.T(spq_req_t)) req_if ();
	spq_stream_if #(.T(spq_rsp_t)) rsp_if ();

	sorted_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always #5 clk = ~clk;

	// Offer one request beat, after a random gap unless calm; hold it until accepted.
	task automatic send_item(input spq_cmd_t cmd, input logic [VALUE_W-1:0] val,
			input logic [PRIO_W-1:0] prio);
		spq_req_t r;
		r.command = cmd;
		r.item_value = val;
		r.item_priority = prio;
		if (!calm) begin
			while ($urandom_range(0, 99) < STALL_PCT) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(r);
		sent++;
	endtask

	function automatic logic [PRIO_W-1:0] pick_prio();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return PRIO_W'($urandom_range(0, 7));
		if (roll < 70) return ($urandom_range(0, 1) != 0) ? {PRIO_W{1'b1}} : {PRIO_W{1'b0}};
		return PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
	endfunction

	// Check response beats and stall the response side at random.
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
		rsp_if.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// End the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, giving up", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		traffic_mode_t mode;
		int burst;
		int enq_pct;
		sb = new();
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dequeue, field extremes, ties, fill to full, refused enqueue, dequeues.
		send_item(CMD_DEQ, 32'h1234_5678, '1);
		send_item(CMD_ENQ, 32'h7FFF_FFFF, '0);
		send_item(CMD_ENQ, 32'h8000_0000, '1);
		send_item(CMD_ENQ, 32'h0000_0000, 15'd5);
		send_item(CMD_ENQ, 32'hFFFF_FFFF, 15'd5);
		send_item(CMD_ENQ, 32'h0000_0001, 15'd5);
		send_item(CMD_ENQ, 32'h5555_5555, '1);
		send_item(CMD_ENQ, 32'hAAAA_AAAA, '0);
		for (int i = 0; i < 9; i++)
			send_item(CMD_ENQ, $urandom(), 15'(i * 3 + 1));
		send_item(CMD_ENQ, 32'h0BAD_F00D, '1);
		repeat (5) send_item(CMD_DEQ, $urandom(), PRIO_W'($urandom()));

		// Random bursts that push the queue toward full, toward empty, or hover.
		while (sent < ITEM_GOAL) begin
			mode = traffic_mode_t'($urandom_range(0, 2));
			case (mode)
				MODE_FILL:  enq_pct = 80;
				MODE_DRAIN: enq_pct = 20;
				default:    enq_pct = 50;
			endcase
			burst = $urandom_range(10, 60);
			for (int i = 0; i < burst && sent < ITEM_GOAL; i++) begin
				calm = (sent >= 700 && sent < 1000);
				if ($urandom_range(0, 99) < enq_pct)
					send_item(CMD_ENQ, $urandom(), pick_prio());
				else
					send_item(CMD_DEQ, $urandom(), PRIO_W'($urandom()));
			end
		end
		calm = 1'b0;
		req_if.valid <= 1'b0;

		// Wait for every predicted response, then let the pipeline settle.
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d enqueues, %0d refused on full, %0d dequeues, %0d on empty.",
			sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
		$display("Peak occupancy %0d of %0d; %0d responses checked, %0d mismatches.",
			sb.peak, SPQ_DEPTH, sb.n_checked, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/spq_pkg.sv
src/spq_stream_if.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
sim/sorted_priority_queue_top_tb.sv
